[rtl/fpms_pkg.sv]
// ----------------------------------------------------------------------------
// fpms_pkg
// Shared types, constants and the ten-row step table of the five-phase
// microstep sequencer.
// ----------------------------------------------------------------------------
package fpms_pkg;

  localparam int unsigned PHASES          = 5;
  localparam int unsigned STEPS_PER_CYCLE = 10;

  localparam logic [15:0] HIGH_MARGIN     = 16'd100;
  localparam logic [15:0] COMPARE_RESET   = 16'd2048;
  localparam logic [3:0]  LAST_STEP       = 4'd9;

  // width of (microstep + 1) * ramp_increment
  localparam int unsigned RAMP_W = 25;

  // phase operations of one table row
  typedef enum logic [2:0] {
    OP_KEEP,
    OP_HIGH,
    OP_SUB_FULL,
    OP_SUB_HALF,
    OP_ADD_EMPTY,
    OP_ADD_HALF
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FULL_PULSE     = 3'd0,
    CFG_HALF_PULSE     = 3'd1,
    CFG_EMPTY_PULSE    = 3'd2,
    CFG_RAMP_INCREMENT = 3'd3,
    CFG_LAST_TICK      = 3'd4,
    CFG_LAST_MICROSTEP = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] full_pulse;
    logic [15:0] half_pulse;
    logic [15:0] empty_pulse;
    logic [15:0] ramp_increment;
    logic [15:0] last_tick_index;
    logic [7:0]  last_microstep_index;
  } cfg_t;

  typedef struct packed {
    op_t [PHASES-1:0] op;
    logic [4:0]       main_set;
    logic [4:0]       main_clr;
    logic [4:0]       comp_set;
    logic [4:0]       comp_clr;
  } row_t;

  // compare values and enable masks held between rows
  typedef struct packed {
    logic [PHASES-1:0][15:0] compare;
    logic [4:0]              main_en;
    logic [4:0]              comp_en;
  } phase_state_t;

  function automatic row_t make_row(op_t a, op_t b, op_t c, op_t d, op_t e,
                                    logic [4:0] ms, logic [4:0] mc,
                                    logic [4:0] cs, logic [4:0] cc);
    row_t r;
    r.op[0]    = a;
    r.op[1]    = b;
    r.op[2]    = c;
    r.op[3]    = d;
    r.op[4]    = e;
    r.main_set = ms;
    r.main_clr = mc;
    r.comp_set = cs;
    r.comp_clr = cc;
    return r;
  endfunction

  // step table, rows beyond the last map to the last row
  function automatic row_t row_lookup(logic [3:0] step);
    row_t r;
    case (step)
      4'd0: r = make_row(OP_SUB_FULL, OP_HIGH, OP_ADD_HALF, OP_KEEP, OP_HIGH,
                         5'h00, 5'h18, 5'h10, 5'h00);
      4'd1: r = make_row(OP_SUB_HALF, OP_HIGH, OP_HIGH, OP_ADD_EMPTY, OP_KEEP,
                         5'h08, 5'h10, 5'h00, 5'h08);
      4'd2: r = make_row(OP_HIGH, OP_SUB_FULL, OP_HIGH, OP_ADD_HALF, OP_KEEP,
                         5'h00, 5'h11, 5'h01, 5'h00);
      4'd3: r = make_row(OP_KEEP, OP_SUB_HALF, OP_HIGH, OP_HIGH, OP_ADD_EMPTY,
                         5'h10, 5'h01, 5'h00, 5'h10);
      4'd4: r = make_row(OP_KEEP, OP_HIGH, OP_SUB_FULL, OP_HIGH, OP_ADD_HALF,
                         5'h00, 5'h03, 5'h02, 5'h00);
      4'd5: r = make_row(OP_ADD_EMPTY, OP_KEEP, OP_SUB_HALF, OP_HIGH, OP_HIGH,
                         5'h01, 5'h02, 5'h00, 5'h01);
      4'd6: r = make_row(OP_ADD_HALF, OP_KEEP, OP_HIGH, OP_SUB_FULL, OP_HIGH,
                         5'h00, 5'h06, 5'h04, 5'h00);
      4'd7: r = make_row(OP_HIGH, OP_ADD_EMPTY, OP_KEEP, OP_SUB_HALF, OP_HIGH,
                         5'h02, 5'h04, 5'h00, 5'h02);
      4'd8: r = make_row(OP_HIGH, OP_ADD_HALF, OP_KEEP, OP_KEEP, OP_SUB_FULL,
                         5'h00, 5'h0C, 5'h08, 5'h00);
      default: r = make_row(OP_HIGH, OP_HIGH, OP_ADD_EMPTY, OP_KEEP, OP_SUB_HALF,
                            5'h04, 5'h08, 5'h00, 5'h04);
    endcase
    return r;
  endfunction

  // a + b, saturating at all ones
  function automatic logic [15:0] sat_add(logic [15:0] a, logic [RAMP_W-1:0] b);
    logic [RAMP_W:0] sum;
    sum = (RAMP_W+1)'(a) + (RAMP_W+1)'(b);
    return (sum > (RAMP_W+1)'(16'hFFFF)) ? 16'hFFFF : sum[15:0];
  endfunction

  // a - b, saturating at zero
  function automatic logic [15:0] sat_sub(logic [15:0] a, logic [RAMP_W-1:0] b);
    return (b >= RAMP_W'(a)) ? 16'd0 : (a - b[15:0]);
  endfunction

endpackage

[rtl/fpms_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fpms_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module fpms_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_addr,
  input  logic [15:0]    cfg_data,
  output fpms_pkg::cfg_t cfg
);

  // register writes, unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_pulse           <= 16'd4096;
      cfg.half_pulse           <= 16'd2048;
      cfg.empty_pulse          <= 16'd81;
      cfg.ramp_increment       <= 16'd81;
      cfg.last_tick_index      <= 16'd137;
      cfg.last_microstep_index <= 8'd21;
    end else if (cfg_we) begin
      case (cfg_addr)
        fpms_pkg::CFG_FULL_PULSE:     cfg.full_pulse           <= cfg_data;
        fpms_pkg::CFG_HALF_PULSE:     cfg.half_pulse           <= cfg_data;
        fpms_pkg::CFG_EMPTY_PULSE:    cfg.empty_pulse          <= cfg_data;
        fpms_pkg::CFG_RAMP_INCREMENT: cfg.ramp_increment       <= cfg_data;
        fpms_pkg::CFG_LAST_TICK:      cfg.last_tick_index      <= cfg_data;
        fpms_pkg::CFG_LAST_MICROSTEP: cfg.last_microstep_index <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/fpms_phase_unit.sv]
// ----------------------------------------------------------------------------
// fpms_phase_unit
// Holds the five compare values and the enable masks and applies one step
// table row to them when asked.
// ----------------------------------------------------------------------------
module fpms_phase_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   apply,
  input  logic [3:0]             step,
  input  logic [7:0]             microstep,
  input  fpms_pkg::cfg_t         cfg,
  output fpms_pkg::phase_state_t state_next
);

  fpms_pkg::phase_state_t          state;
  fpms_pkg::row_t                  row;
  logic [8:0]                      microstep_plus;
  logic [fpms_pkg::RAMP_W-1:0]     ramp;
  logic [15:0]                     high_value;

  // ramp amount and row decode
  always_comb begin
    row            = fpms_pkg::row_lookup(step);
    microstep_plus = 9'(microstep) + 9'd1;
    ramp           = fpms_pkg::RAMP_W'(microstep_plus)
                   * fpms_pkg::RAMP_W'(cfg.ramp_increment);
    high_value     = fpms_pkg::sat_add(cfg.full_pulse,
                                       fpms_pkg::RAMP_W'(fpms_pkg::HIGH_MARGIN));
  end

  // per-phase update and mask set/clear
  always_comb begin
    state_next = state;
    for (int p = 0; p < fpms_pkg::PHASES; p++) begin
      case (row.op[p])
        fpms_pkg::OP_HIGH:
          state_next.compare[p] = high_value;
        fpms_pkg::OP_SUB_FULL:
          state_next.compare[p] = fpms_pkg::sat_sub(cfg.full_pulse, ramp);
        fpms_pkg::OP_SUB_HALF:
          state_next.compare[p] = fpms_pkg::sat_sub(cfg.half_pulse, ramp);
        fpms_pkg::OP_ADD_EMPTY:
          state_next.compare[p] = fpms_pkg::sat_add(cfg.empty_pulse, ramp);
        fpms_pkg::OP_ADD_HALF:
          state_next.compare[p] = fpms_pkg::sat_add(cfg.half_pulse, ramp);
        default: ;
      endcase
    end
    state_next.main_en = (state.main_en & ~row.main_clr) | row.main_set;
    state_next.comp_en = (state.comp_en & ~row.comp_clr) | row.comp_set;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < fpms_pkg::PHASES; p++) begin
        state.compare[p] <= fpms_pkg::COMPARE_RESET;
      end
      state.main_en <= 5'h1F;
      state.comp_en <= 5'h1F;
    end else if (apply) begin
      state <= state_next;
    end
  end

endmodule

[rtl/five_phase_microstep_sequencer_core.sv]
// ----------------------------------------------------------------------------
// five_phase_microstep_sequencer_core
// A tick transfer fills the input register; when that stage goes on, the row
// update is written into the output register. A result tick waits in the
// input register while the output holds an untaken result.
// Throughput: one tick per cycle save such waits (single counter/row stage).
// Reset: synchronous; counters clear, compares return to 2048, masks to all
// ones, registers to their defaults and both pipeline stages empty.
// ----------------------------------------------------------------------------
module five_phase_microstep_sequencer_core (
  input  logic          clk,
  input  logic          rst,
  // slave side: [0] tick
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,
  // master side: [15:0] compare_a, [31:16] compare_b, [47:32] compare_c,
  // [63:48] compare_d, [79:64] compare_e, [84:80] main_enable_mask,
  // [89:85] comp_enable_mask, [93:90] step_index, [101:94] microstep_index
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,
  // configuration write port
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [15:0]   cfg_data
);

  fpms_pkg::cfg_t         cfg;
  fpms_pkg::phase_state_t state_next;

  logic        s1_valid;
  logic        s1_tick;
  logic        s1_produce;
  logic        s1_go;
  logic        out_free;
  logic        advance;
  logic        load;

  logic [15:0] tick_counter;
  logic [15:0] tick_counter_next;
  logic [7:0]  microstep_counter;
  logic [7:0]  microstep_counter_next;
  logic [3:0]  step_counter;
  logic [3:0]  step_counter_next;

  fpms_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  fpms_phase_unit u_phase (
    .clk        (clk),
    .rst        (rst),
    .apply      (load),
    .step       (step_counter),
    .microstep  (microstep_counter),
    .cfg        (cfg),
    .state_next (state_next)
  );

  // stage handshake: a tick that gives no result never waits on the output
  assign s1_produce    = s1_valid & s1_tick & (tick_counter == 16'd0);
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign s1_go         = s1_valid & (~s1_produce | out_free);
  assign s_axis_tready = ~s1_valid | s1_go;
  assign advance       = s1_go & s1_tick;
  assign load          = s1_go & s1_produce;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_tick <= s_axis_tdata[0];
    end
  end

  // tick, microstep and full step counters
  always_comb begin
    tick_counter_next      = tick_counter + 16'd1;
    microstep_counter_next = microstep_counter;
    step_counter_next      = step_counter;
    if (tick_counter >= cfg.last_tick_index) begin
      tick_counter_next = 16'd0;
      if (microstep_counter >= cfg.last_microstep_index) begin
        microstep_counter_next = 8'd0;
        if (step_counter >= fpms_pkg::LAST_STEP) begin
          step_counter_next = 4'd0;
        end else begin
          step_counter_next = step_counter + 4'd1;
        end
      end else begin
        microstep_counter_next = microstep_counter + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter      <= 16'd0;
      microstep_counter <= 8'd0;
      step_counter      <= 4'd0;
    end else if (advance) begin
      tick_counter      <= tick_counter_next;
      microstep_counter <= microstep_counter_next;
      step_counter      <= step_counter_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {2'b00, microstep_counter, step_counter,
                       state_next.comp_en, state_next.main_en,
                       state_next.compare[4], state_next.compare[3],
                       state_next.compare[2], state_next.compare[1],
                       state_next.compare[0]};
    end
  end

  // full step counter stays inside the table
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_counter <= fpms_pkg::LAST_STEP)
    else $error("step counter outside table");

  // a tick at tick counter zero shows up as a result on the next edge
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_tick && tick_counter == 16'd0) |=> m_axis_tvalid)
    else $error("result missing after row update");

  // below the wrap point the tick counter counts up by one
  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    (advance && tick_counter < cfg.last_tick_index)
    |=> tick_counter == 16'($past(tick_counter) + 16'd1))
    else $error("tick counter did not advance");

  // the input side only stalls behind a held item
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting result");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the five-phase microstep sequencer core. Tick
// transfers are driven from a queue with random source gaps and sink stalls.
// A local step-table predictor tracks the counters, compares and enable masks
// and checks every result transfer field by field. The bench rewrites the
// registers between phases, each time once the core has gone idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned MAX_REPORTS    = 10;

  // one row of the step table as seen by the predictor
  typedef struct packed {
    fpms_pkg::op_t [fpms_pkg::PHASES-1:0] op;
    logic [4:0]                           main_set;
    logic [4:0]                           main_clr;
    logic [4:0]                           comp_set;
    logic [4:0]                           comp_clr;
  } step_row_t;

  // master-side tdata layout, compare_a in the lowest bits
  typedef struct packed {
    logic [1:0]  pad;
    logic [7:0]  microstep_index;
    logic [3:0]  step_index;
    logic [4:0]  comp_enable_mask;
    logic [4:0]  main_enable_mask;
    logic [15:0] compare_e;
    logic [15:0] compare_d;
    logic [15:0] compare_c;
    logic [15:0] compare_b;
    logic [15:0] compare_a;
  } phase_update_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'd0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = fpms_pkg::CFG_FULL_PULSE;
  logic [15:0]  cfg_data = 16'd0;

  // stimulus and expectation stores
  logic          tick_queue[$];
  phase_update_t update_q[$];
  int unsigned   ticks_queued = 0;
  int unsigned   ticks_accepted = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   stall_cycles = 0;
  bit            tick_sent = 1'b0;
  bit            src_idle_on = 1'b1;
  bit            sink_idle_on = 1'b1;
  int unsigned   src_gap = 0;
  int unsigned   sink_gap = 0;

  // predictor registers
  logic [15:0] full_pulse = 16'd4096;
  logic [15:0] half_pulse = 16'd2048;
  logic [15:0] empty_pulse = 16'd81;
  logic [15:0] ramp_inc = 16'd81;
  logic [15:0] last_tick = 16'd137;
  logic [7:0]  last_micro = 8'd21;

  // predictor state
  logic [15:0] tick_cnt = 16'd0;
  logic [7:0]  micro_cnt = 8'd0;
  logic [3:0]  step_cnt = 4'd0;
  logic [15:0] phase_cmp [fpms_pkg::PHASES] = '{default: fpms_pkg::COMPARE_RESET};
  logic [4:0]  main_en = 5'h1F;
  logic [4:0]  comp_en = 5'h1F;

  five_phase_microstep_sequencer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic step_row_t mk_row(fpms_pkg::op_t a, fpms_pkg::op_t b,
                                       fpms_pkg::op_t c, fpms_pkg::op_t d,
                                       fpms_pkg::op_t e,
                                       logic [4:0] ms, logic [4:0] mc,
                                       logic [4:0] cs, logic [4:0] cc);
    step_row_t r;
    r.op[0]    = a;
    r.op[1]    = b;
    r.op[2]    = c;
    r.op[3]    = d;
    r.op[4]    = e;
    r.main_set = ms;
    r.main_clr = mc;
    r.comp_set = cs;
    r.comp_clr = cc;
    return r;
  endfunction

  // ten-row phase table, out-of-range steps use the last row
  function automatic step_row_t row_for_step(logic [3:0] s);
    case (s)
      4'd0: return mk_row(fpms_pkg::OP_SUB_FULL, fpms_pkg::OP_HIGH,
                          fpms_pkg::OP_ADD_HALF, fpms_pkg::OP_KEEP, fpms_pkg::OP_HIGH,
                          5'h00, 5'h18, 5'h10, 5'h00);
      4'd1: return mk_row(fpms_pkg::OP_SUB_HALF, fpms_pkg::OP_HIGH,
                          fpms_pkg::OP_HIGH, fpms_pkg::OP_ADD_EMPTY, fpms_pkg::OP_KEEP,
                          5'h08, 5'h10, 5'h00, 5'h08);
      4'd2: return mk_row(fpms_pkg::OP_HIGH, fpms_pkg::OP_SUB_FULL,
                          fpms_pkg::OP_HIGH, fpms_pkg::OP_ADD_HALF, fpms_pkg::OP_KEEP,
                          5'h00, 5'h11, 5'h01, 5'h00);
      4'd3: return mk_row(fpms_pkg::OP_KEEP, fpms_pkg::OP_SUB_HALF,
                          fpms_pkg::OP_HIGH, fpms_pkg::OP_HIGH, fpms_pkg::OP_ADD_EMPTY,
                          5'h10, 5'h01, 5'h00, 5'h10);
      4'd4: return mk_row(fpms_pkg::OP_KEEP, fpms_pkg::OP_HIGH,
                          fpms_pkg::OP_SUB_FULL, fpms_pkg::OP_HIGH, fpms_pkg::OP_ADD_HALF,
                          5'h00, 5'h03, 5'h02, 5'h00);
      4'd5: return mk_row(fpms_pkg::OP_ADD_EMPTY, fpms_pkg::OP_KEEP,
                          fpms_pkg::OP_SUB_HALF, fpms_pkg::OP_HIGH, fpms_pkg::OP_HIGH,
                          5'h01, 5'h02, 5'h00, 5'h01);
      4'd6: return mk_row(fpms_pkg::OP_ADD_HALF, fpms_pkg::OP_KEEP,
                          fpms_pkg::OP_HIGH, fpms_pkg::OP_SUB_FULL, fpms_pkg::OP_HIGH,
                          5'h00, 5'h06, 5'h04, 5'h00);
      4'd7: return mk_row(fpms_pkg::OP_HIGH, fpms_pkg::OP_ADD_EMPTY,
                          fpms_pkg::OP_KEEP, fpms_pkg::OP_SUB_HALF, fpms_pkg::OP_HIGH,
                          5'h02, 5'h04, 5'h00, 5'h02);
      4'd8: return mk_row(fpms_pkg::OP_HIGH, fpms_pkg::OP_ADD_HALF,
                          fpms_pkg::OP_KEEP, fpms_pkg::OP_KEEP, fpms_pkg::OP_SUB_FULL,
                          5'h00, 5'h0C, 5'h08, 5'h00);
      default: return mk_row(fpms_pkg::OP_HIGH, fpms_pkg::OP_HIGH,
                             fpms_pkg::OP_ADD_EMPTY, fpms_pkg::OP_KEEP,
                             fpms_pkg::OP_SUB_HALF,
                             5'h04, 5'h08, 5'h00, 5'h04);
    endcase
  endfunction

  function automatic logic [15:0] sat_plus(logic [15:0] a, logic [31:0] b);
    logic [31:0] s;
    s = 32'(a) + b;
    return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] sat_minus(logic [15:0] a, logic [31:0] b);
    return (b >= 32'(a)) ? 16'd0 : (a - b[15:0]);
  endfunction

  // apply one accepted tick to the predictor, queue the update it gives
  task automatic advance_sequencer(input logic tick_bit);
    step_row_t     row;
    logic [31:0]   ramp;
    phase_update_t upd;
    if (!tick_bit) return;
    if (tick_cnt == 16'd0) begin
      row  = row_for_step(step_cnt);
      ramp = (32'(micro_cnt) + 32'd1) * 32'(ramp_inc);
      for (int p = 0; p < fpms_pkg::PHASES; p++) begin
        case (row.op[p])
          fpms_pkg::OP_HIGH:
            phase_cmp[p] = sat_plus(full_pulse, 32'(fpms_pkg::HIGH_MARGIN));
          fpms_pkg::OP_SUB_FULL:  phase_cmp[p] = sat_minus(full_pulse, ramp);
          fpms_pkg::OP_SUB_HALF:  phase_cmp[p] = sat_minus(half_pulse, ramp);
          fpms_pkg::OP_ADD_EMPTY: phase_cmp[p] = sat_plus(empty_pulse, ramp);
          fpms_pkg::OP_ADD_HALF:  phase_cmp[p] = sat_plus(half_pulse, ramp);
          default: ;
        endcase
      end
      main_en = (main_en & ~row.main_clr) | row.main_set;
      comp_en = (comp_en & ~row.comp_clr) | row.comp_set;
      upd = '0;
      upd.compare_a        = phase_cmp[0];
      upd.compare_b        = phase_cmp[1];
      upd.compare_c        = phase_cmp[2];
      upd.compare_d        = phase_cmp[3];
      upd.compare_e        = phase_cmp[4];
      upd.main_enable_mask = main_en;
      upd.comp_enable_mask = comp_en;
      upd.step_index       = step_cnt;
      upd.microstep_index  = micro_cnt;
      update_q.push_back(upd);
    end
    // tick, microstep and full-step counters
    if (tick_cnt >= last_tick) begin
      tick_cnt = 16'd0;
      if (micro_cnt >= last_micro) begin
        micro_cnt = 8'd0;
        step_cnt  = (step_cnt >= fpms_pkg::LAST_STEP) ? 4'd0 : step_cnt + 4'd1;
      end else begin
        micro_cnt = micro_cnt + 8'd1;
      end
    end else begin
      tick_cnt = tick_cnt + 16'd1;
    end
  endtask

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", field, want, got);
  endtask

  // compare one result transfer with the oldest pending update
  task automatic check_update(input logic [103:0] data);
    phase_update_t got;
    phase_update_t want;
    got = phase_update_t'(data);
    if (update_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch: result transfer with nothing pending, data %h", data);
      return;
    end
    want = update_q.pop_front();
    if (got.compare_a !== want.compare_a)
      note_mismatch("compare_a", want.compare_a, got.compare_a);
    if (got.compare_b !== want.compare_b)
      note_mismatch("compare_b", want.compare_b, got.compare_b);
    if (got.compare_c !== want.compare_c)
      note_mismatch("compare_c", want.compare_c, got.compare_c);
    if (got.compare_d !== want.compare_d)
      note_mismatch("compare_d", want.compare_d, got.compare_d);
    if (got.compare_e !== want.compare_e)
      note_mismatch("compare_e", want.compare_e, got.compare_e);
    if (got.main_enable_mask !== want.main_enable_mask)
      note_mismatch("main_enable_mask", want.main_enable_mask, got.main_enable_mask);
    if (got.comp_enable_mask !== want.comp_enable_mask)
      note_mismatch("comp_enable_mask", want.comp_enable_mask, got.comp_enable_mask);
    if (got.step_index !== want.step_index)
      note_mismatch("step_index", want.step_index, got.step_index);
    if (got.microstep_index !== want.microstep_index)
      note_mismatch("microstep_index", want.microstep_index, got.microstep_index);
  endtask

  // monitor: check result transfers, feed tick transfers to the predictor
  always @(posedge clk) begin : monitor
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        check_update(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        advance_sequencer(s_axis_tdata[0]);
        tick_sent = 1'b1;
        ticks_accepted++;
      end
      // watchdog on cycles with no transfer on either side
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  // tick driver with random source gaps
  always @(negedge clk) begin : drive_ticks
    logic nv;
    nv = s_axis_tvalid;
    if (tick_sent) begin
      void'(tick_queue.pop_front());
      tick_sent = 1'b0;
      nv = 1'b0;
    end
    if (!nv) begin
      if (src_gap != 0) begin
        src_gap--;
      end else if (tick_queue.size() != 0) begin
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 9);
        end else begin
          nv = 1'b1;
          s_axis_tdata = {7'd0, tick_queue[0]};
        end
      end
    end
    s_axis_tvalid = nv;
  end

  // result sink with random stall bursts
  always @(negedge clk) begin : drive_ready
    if (sink_gap != 0) begin
      sink_gap--;
      m_axis_tready = 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 9);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic push_tick(input logic t);
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // queue a run of ticks, on average ones_of_8 out of eight carry a set tick bit
  task automatic queue_ticks(input int unsigned n, input int unsigned ones_of_8);
    @(posedge clk);
    repeat (n) push_tick($urandom_range(0, 7) < ones_of_8);
  endtask

  task automatic wait_idle();
    while (ticks_accepted != ticks_queued || update_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, mirrored into the predictor while the core is idle
  task automatic write_reg(input fpms_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    case (idx)
      fpms_pkg::CFG_FULL_PULSE:     full_pulse  = val;
      fpms_pkg::CFG_HALF_PULSE:     half_pulse  = val;
      fpms_pkg::CFG_EMPTY_PULSE:    empty_pulse = val;
      fpms_pkg::CFG_RAMP_INCREMENT: ramp_inc    = val;
      fpms_pkg::CFG_LAST_TICK:      last_tick   = val;
      fpms_pkg::CFG_LAST_MICROSTEP: last_micro  = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_pulses(input logic [15:0] full, input logic [15:0] half,
                              input logic [15:0] empty, input logic [15:0] inc);
    write_reg(fpms_pkg::CFG_FULL_PULSE, full);
    write_reg(fpms_pkg::CFG_HALF_PULSE, half);
    write_reg(fpms_pkg::CFG_EMPTY_PULSE, empty);
    write_reg(fpms_pkg::CFG_RAMP_INCREMENT, inc);
  endtask

  function automatic logic [15:0] pick_pulse();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(0, 8191));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_last_tick();
    case ($urandom_range(0, 15))
      0:       return 16'hFFFF;
      1, 2:    return 16'($urandom_range(4, 40));
      default: return 16'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [15:0] pick_last_micro();
    case ($urandom_range(0, 7))
      0:       return 16'd255;
      1:       return 16'($urandom_range(16, 254));
      default: return 16'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin : stimulus
    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default registers: first tick applies row zero, an empty tick does nothing
    @(posedge clk);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b1);
    wait_idle();

    // one result per set tick once the tick counter has wrapped, full step advances every set tick: all ten rows
    write_pulses(16'd4096, 16'd2048, 16'd81, 16'd81);
    write_reg(fpms_pkg::CFG_LAST_TICK, 16'd0);
    write_reg(fpms_pkg::CFG_LAST_MICROSTEP, 16'd0);
    @(posedge clk);
    repeat (6) push_tick(1'b1);
    push_tick(1'b0);
    repeat (6) push_tick(1'b1);
    wait_idle();

    // saturation at the top of every sum and the held-high value
    write_pulses(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(fpms_pkg::CFG_LAST_MICROSTEP, 16'd1);
    queue_ticks(5, 8);
    wait_idle();

    // all-zero pulses and increment
    write_pulses(16'd0, 16'd0, 16'd0, 16'd0);
    queue_ticks(4, 8);
    wait_idle();

    // random phases with random register settings
    while (ticks_queued < 600) begin
      if ($urandom_range(0, 1)) write_reg(fpms_pkg::CFG_FULL_PULSE, pick_pulse());
      if ($urandom_range(0, 1)) write_reg(fpms_pkg::CFG_HALF_PULSE, pick_pulse());
      if ($urandom_range(0, 1)) write_reg(fpms_pkg::CFG_EMPTY_PULSE, pick_pulse());
      if ($urandom_range(0, 1)) write_reg(fpms_pkg::CFG_RAMP_INCREMENT, pick_pulse());
      write_reg(fpms_pkg::CFG_LAST_TICK, pick_last_tick());
      write_reg(fpms_pkg::CFG_LAST_MICROSTEP, pick_last_micro());
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      queue_ticks($urandom_range(20, 70), 7);
      wait_idle();
    end

    // widest microstep range, so the ramp reaches its largest factor
    write_pulses(pick_pulse(), pick_pulse(), pick_pulse(), 16'($urandom_range(1, 65535)));
    write_reg(fpms_pkg::CFG_LAST_TICK, 16'd0);
    write_reg(fpms_pkg::CFG_LAST_MICROSTEP, 16'd255);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    queue_ticks(270, 8);
    wait_idle();

    // closing stretch without idling on either side
    write_pulses(pick_pulse(), pick_pulse(), pick_pulse(), pick_pulse());
    write_reg(fpms_pkg::CFG_LAST_TICK, 16'($urandom_range(0, 2)));
    write_reg(fpms_pkg::CFG_LAST_MICROSTEP, 16'($urandom_range(0, 5)));
    @(posedge clk);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    queue_ticks(80, 7);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += update_q.size();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fpms_pkg.sv
rtl/fpms_cfg_regs.sv
rtl/fpms_phase_unit.sv
rtl/five_phase_microstep_sequencer_core.sv
dv/tb_top.sv
